// File: design/per_source_duplicate_filter_assert.svh
// Assertion macros used by the duplicate filter sequencer (pdf_seq).
`ifndef PER_SOURCE_DUPLICATE_FILTER_ASSERT_SVH
`define PER_SOURCE_DUPLICATE_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while out of reset.
`define PDF_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PDF_ASSERT_ON(lbl, clk, rst_n, prop, msg)
`define PDF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: design/pdf_pkg.sv
package pdf_pkg;

    localparam int PDF_ENTRIES = 16;
    localparam int MAC_W       = 48;
    localparam int SEQ_W       = 8;

    typedef struct packed {
        logic [MAC_W-1:0] source_mac;
        logic             has_source;
        logic [SEQ_W-1:0] seq_id;
    } pdf_in_t;

    typedef struct packed {
        logic is_duplicate;
        logic table_full;
    } pdf_out_t;

    // One table row: sender address and the last sequence id seen from it.
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [SEQ_W-1:0] seq;
    } pdf_row_t;

    // Table port control from the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } pdf_mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_DONE
    } pdf_state_t;

endpackage

// File: design/pdf_seq.sv
`include "per_source_duplicate_filter_assert.svh"

module pdf_seq
    import pdf_pkg::*;
#(
    parameter int ENTRIES = PDF_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pdf_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pdf_out_t         out_data,
    output pdf_mem_ctl_t     mem_ctl,
    output logic [IDX_W-1:0] mem_addr,
    output pdf_row_t         mem_wdata,
    input  pdf_row_t         mem_rdata
);

    pdf_state_t       state_reg, state_next;
    pdf_in_t          item_reg, item_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             dup_reg, dup_next;
    logic             full_reg, full_next;
    logic             out_valid_reg, out_valid_next;
    pdf_out_t         out_reg, out_next;

    logic             accept;
    logic             skip;
    logic             addr_hit;
    logic             last_row;
    logic             slot_free;
    logic             is_full;

    assign accept    = in_valid && in_ready;
    // Frames without a sender or with id zero bypass the table entirely.
    assign skip      = !in_data.has_source || (in_data.seq_id == '0);
    assign addr_hit  = (mem_rdata.mac == item_reg.source_mac);
    assign last_row  = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign slot_free = !out_valid_reg || out_ready;
    assign is_full   = (used_reg == CNT_W'(ENTRIES));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (skip)
                        state_next = ST_DONE;
                    else if (used_reg == '0)
                        state_next = ST_APPEND;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_hit)
                    state_next = ST_DONE;
                else if (last_row)
                    state_next = ST_APPEND;
            end
            ST_APPEND:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake and table port control.
    always_comb
    begin
        in_ready  = 1'b0;
        mem_ctl   = '0;
        mem_addr  = idx_reg;
        mem_wdata = '{mac: item_reg.source_mac, seq: item_reg.seq_id};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                mem_ctl.rd_en = accept && !skip;
                mem_addr      = '0;
            end
            ST_SCAN:
            begin
                if (addr_hit)
                begin
                    // Known sender: store the new id unless it repeats.
                    mem_ctl.wr_en = (mem_rdata.seq != item_reg.seq_id);
                    mem_addr      = idx_reg;
                end
                else if (!last_row)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = IDX_W'(CNT_W'(idx_reg) + CNT_W'(1));
                end
            end
            ST_APPEND:
            begin
                mem_ctl.wr_en = !is_full;
                mem_addr      = used_reg[IDX_W-1:0];
            end
            ST_DONE:
                mem_ctl = '0;
            default:
                mem_ctl = '0;
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        item_next      = item_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        dup_next       = dup_reg;
        full_next      = full_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    idx_next  = '0;
                    dup_next  = 1'b0;
                    full_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (addr_hit)
                    dup_next = (mem_rdata.seq == item_reg.seq_id);
                else if (!last_row)
                    idx_next = IDX_W'(CNT_W'(idx_reg) + CNT_W'(1));
            end
            ST_APPEND:
            begin
                if (is_full)
                    full_next = 1'b1;
                else
                    used_next = used_reg + CNT_W'(1);
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{is_duplicate: dup_reg, table_full: full_reg};
                end
            end
            default:
                idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        dup_reg  <= dup_next;
        full_reg <= full_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PDF_ASSERT_ON(a_used_bound, clk, rst_n, used_reg <= CNT_W'(ENTRIES), "row count beyond table size")
    `PDF_ASSERT_ON(a_wr_state, clk, rst_n, mem_ctl.wr_en |-> (state_reg == ST_SCAN || state_reg == ST_APPEND), "table write outside scan or append")
    `PDF_ASSERT_ON(a_full_only_when_full, clk, rst_n, (state_reg == ST_DONE && full_reg) |-> is_full, "full flag with free rows")
    `PDF_ASSERT_ON(a_accept_leaves_idle, clk, rst_n, accept |=> state_reg != ST_IDLE, "accepted frame not processed")
    `PDF_ASSERT_ON(a_flags_exclusive, clk, rst_n, out_valid_reg |-> !(out_reg.is_duplicate && out_reg.table_full), "duplicate and full flagged together")

endmodule

// File: design/per_source_duplicate_filter.sv
// Channel | Signals                      | Transfer when
// --------+------------------------------+-----------------------
// input   | in_valid, in_ready, in_data  | in_valid && in_ready
// output  | out_valid, out_ready, out_data | out_valid && out_ready
//
// A frame is compared against one occupied table row per cycle through a
// single table read port and one address comparator.
// A frame that bypasses the table goes straight to its result; otherwise rows are scanned
// in order until the sender is found, and an unseen sender is appended after the last row.
// Reset clears the row count and the handshake state; table rows need no clearing.
// A waiting result sits in the output register, so the next frame is taken while
// it stalls; a second result waits in the sequencer until that register frees.
module per_source_duplicate_filter
    import pdf_pkg::*;
#(
    parameter int ENTRIES = PDF_ENTRIES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pdf_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pdf_out_t out_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    pdf_mem_ctl_t     mem_ctl;
    logic [IDX_W-1:0] mem_addr;
    pdf_row_t         mem_wdata;
    pdf_row_t         rd_data_reg;
    pdf_row_t         table_mem [ENTRIES];

    pdf_seq #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (rd_data_reg)
    );

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
            table_mem[mem_addr] <= mem_wdata;
        if (mem_ctl.rd_en)
            rd_data_reg <= table_mem[mem_addr];
    end

endmodule

// File: tb/per_source_duplicate_filter_tb.sv
`timescale 1ns / 100ps

module per_source_duplicate_filter_tb;
    import pdf_pkg::*;

    localparam int RANDOM_FRAMES = 825;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    // Keeps its own copy of the sender table and the verdicts still owed by the block.
    class sender_table_model;
        logic [MAC_W-1:0] row_mac [PDF_ENTRIES];
        logic [SEQ_W-1:0] row_seq [PDF_ENTRIES];
        int unsigned      rows_used;
        pdf_out_t         pending_verdicts [$];
        int unsigned      mismatches;
        int unsigned      frames;
        int unsigned      duplicates;
        int unsigned      rejections;

        function new();
            rows_used  = 0;
            mismatches = 0;
            frames     = 0;
            duplicates = 0;
            rejections = 0;
        endfunction

        function void note_frame(pdf_in_t frame);
            pdf_out_t    verdict;
            bit          found;
            int unsigned i;
            verdict = '0;
            found   = 1'b0;
            frames++;
            if (frame.has_source && frame.seq_id != '0)
            begin
                // The first occupied row with a matching address decides the outcome.
                for (i = 0; i < rows_used && !found; i++)
                begin
                    if (row_mac[i] == frame.source_mac)
                    begin
                        found = 1'b1;
                        if (row_seq[i] == frame.seq_id)
                            verdict.is_duplicate = 1'b1;
                        else
                            row_seq[i] = frame.seq_id;
                    end
                end
                if (!found)
                begin
                    if (rows_used < PDF_ENTRIES)
                    begin
                        row_mac[rows_used] = frame.source_mac;
                        row_seq[rows_used] = frame.seq_id;
                        rows_used++;
                    end
                    else
                        verdict.table_full = 1'b1;
                end
            end
            if (verdict.is_duplicate)
                duplicates++;
            if (verdict.table_full)
                rejections++;
            pending_verdicts.insert(pending_verdicts.size(), verdict);
        endfunction

        function void check_result(pdf_out_t got);
            pdf_out_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("Result with no frame waiting: is_duplicate=%0b table_full=%0b",
                       got.is_duplicate, got.table_full);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.is_duplicate !== want.is_duplicate)
            begin
                $error("is_duplicate: expected %0b, actual %0b",
                       want.is_duplicate, got.is_duplicate);
                mismatches++;
            end
            if (got.table_full !== want.table_full)
            begin
                $error("table_full: expected %0b, actual %0b",
                       want.table_full, got.table_full);
                mismatches++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    pdf_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    pdf_out_t out_data;

    sender_table_model model;
    int unsigned       idle_cycles = 0;
    bit                steady_phase = 1'b0;

    // Every sender address offered with an id, in order of first use, and its last id.
    logic [MAC_W-1:0] known_macs [$];
    logic [SEQ_W-1:0] known_seqs [$];

    per_source_duplicate_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [MAC_W-1:0] mac;
        mac = {16'($urandom), 32'($urandom)};
        return mac;
    endfunction

    // Mostly senders that made it into the table, sometimes any sender seen so far.
    function automatic int unsigned pick_known();
        int unsigned span;
        span = (known_macs.size() < PDF_ENTRIES) ? known_macs.size() : PDF_ENTRIES;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, span - 1);
        return $urandom_range(0, known_macs.size() - 1);
    endfunction

    task automatic send_frame(input pdf_in_t frame);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic offer(input logic [MAC_W-1:0] mac, input logic has_src,
                         input logic [SEQ_W-1:0] seq);
        pdf_in_t     frame;
        bit          listed;
        int unsigned i;
        frame.source_mac = mac;
        frame.has_source = has_src;
        frame.seq_id     = seq;
        listed           = 1'b0;
        if (has_src && seq != '0)
        begin
            for (i = 0; i < known_macs.size() && !listed; i++)
            begin
                if (known_macs[i] == mac)
                begin
                    known_seqs[i] = seq;
                    listed = 1'b1;
                end
            end
            if (!listed)
            begin
                known_macs.insert(known_macs.size(), mac);
                known_seqs.insert(known_seqs.size(), seq);
            end
        end
        send_frame(frame);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && in_ready)
            begin
                model.note_frame(in_data);
                idle_cycles = 0;
            end
            if (out_valid && out_ready)
            begin
                model.check_result(out_data);
                idle_cycles = 0;
            end
        end
    end

    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        wait (rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int unsigned      k;
        int unsigned      r;
        int unsigned      idx;
        int unsigned      directed_frames;
        logic [MAC_W-1:0] ones;
        ones  = '1;
        model = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No sender, then id zero: neither may touch the table.
        offer(ones, 1'b0, 8'd5);
        offer('0, 1'b1, 8'd0);
        // New sender, repeat, new id, repeat again.
        offer('0, 1'b1, 8'd255);
        offer('0, 1'b1, 8'd255);
        offer('0, 1'b1, 8'd1);
        offer('0, 1'b1, 8'd1);
        offer(ones, 1'b1, 8'd1);
        offer(ones, 1'b1, 8'd1);
        // A matching id without a sender is still not a duplicate.
        offer('0, 1'b0, 8'd1);
        offer(48'h8000_0000_0000, 1'b1, 8'd128);
        // Fill the remaining rows, hit the last row, then overflow the table.
        for (k = 3; k < PDF_ENTRIES; k++)
            offer(random_mac(), 1'b1, 8'($urandom_range(1, 255)));
        offer(known_macs[PDF_ENTRIES-1], 1'b1, known_seqs[PDF_ENTRIES-1]);
        offer(random_mac(), 1'b1, 8'($urandom_range(1, 255)));
        directed_frames = model.frames;

        for (k = 0; k < RANDOM_FRAMES; k++)
        begin
            if ($urandom_range(0, 59) == 0)
                steady_phase = ~steady_phase;
            r   = $urandom_range(0, 99);
            idx = pick_known();
            if (r < 6)
                offer(random_mac(), 1'b0, 8'($urandom_range(0, 255)));
            else if (r < 11)
                offer(known_macs[idx], 1'b1, 8'd0);
            else if (r < 51)
                offer(known_macs[idx], 1'b1, known_seqs[idx]);
            else if (r < 76)
                offer(known_macs[idx], 1'b1, 8'($urandom_range(1, 255)));
            else if (r < 84)
                // One flipped address bit must not match the stored sender.
                offer(known_macs[idx] ^ (48'd1 << $urandom_range(0, MAC_W - 1)), 1'b1,
                      8'($urandom_range(1, 255)));
            else
                offer(random_mac(), 1'b1, 8'($urandom_range(1, 255)));
        end
        in_valid <= 1'b0;

        while (model.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Frames checked: %0d (%0d directed); duplicates flagged: %0d; turned away by a full table: %0d.",
                 model.frames, directed_frames, model.duplicates, model.rejections);
        $display("Sender rows occupied at the end: %0d of %0d; mismatches: %0d.",
                 model.rows_used, PDF_ENTRIES, model.mismatches);
        if (model.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
